[rtl/nns_pkg.sv]
package nns_pkg;

    localparam int STORE_DEPTH = 131072;
    localparam int MAX_DIM     = 1024;

    localparam int POS_W     = 10;
    localparam int DIM_W     = 11;
    localparam int COL_W     = 8;
    localparam int PIX_W     = 3 * COL_W;
    localparam int NUM_W     = POS_W + DIM_W;
    localparam int ADDR_W    = 2 * DIM_W + 1;
    localparam int ST_AW     = $clog2(STORE_DEPTH);
    localparam int DIV_CNT_W = $clog2(NUM_W + 1);
    localparam int CFG_IDX_W = 2;
    localparam int OUT_W     = 16;

    localparam logic [OUT_W-1:0] MASK_R565  = 16'hF800;
    localparam logic [OUT_W-1:0] MASK_G565  = 16'h07E0;
    localparam logic [OUT_W-1:0] MASK_B565  = 16'h001F;
    localparam int               R565_SHIFT = 11;
    localparam int               G565_SHIFT = 5;

    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_FETCH = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

    typedef struct packed {
        logic             operation;
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [COL_W-1:0] red;
        logic [COL_W-1:0] green;
        logic [COL_W-1:0] blue;
    } t_in_item;

    typedef struct packed {
        logic [OUT_W-1:0] pixel_565;
        logic [OUT_W-1:0] pixel_swapped;
        logic             out_of_range;
    } t_out_item;

    typedef struct packed {
        logic             we;
        logic             re;
        logic [ST_AW-1:0] addr;
        logic [PIX_W-1:0] wdata;
    } t_store_req;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        return (v > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : v;
    endfunction

    function automatic logic [OUT_W-1:0] pack565(input logic [PIX_W-1:0] rgb);
        logic [OUT_W-1:0] r;
        logic [OUT_W-1:0] g;
        logic [OUT_W-1:0] b;
        r = OUT_W'(rgb[23:19]);
        g = OUT_W'(rgb[15:10]);
        b = OUT_W'(rgb[7:3]);
        return ((r << R565_SHIFT) & MASK_R565) | ((g << G565_SHIFT) & MASK_G565)
               | (b & MASK_B565);
    endfunction

endpackage

[rtl/nearest_neighbor_scaler_rgb565_unit.sv]
// Nearest-neighbour scaler over a 131072 x 24-bit frame store, one item at a time. A load
// beat passes through acceptance, the address multiply and the store write. A fetch beat
// presents its result in the same cycle that the input becomes ready again. Most of its
// time is spent in the two bit-serial dividers that map the destination column and row.
// They find 21 quotient bits at one bit per cycle, then signal completion. Around them sit
// the preparation state, the address multiply, the registered store read and the output
// register. A fetch rejected at the destination bounds check goes from preparation straight
// to the result state. A result that is held at the output holds back the following fetch
// at its final stage. The store is not cleared after reset; every source pixel must be
// loaded before it is fetched. Configuration writes are always accepted and must only be
// issued while the block is idle.
module nearest_neighbor_scaler_rgb565_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [nns_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nns_pkg::DIM_W-1:0]     i_cfg_data,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  nns_pkg::t_in_item             i_in,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output nns_pkg::t_out_item            o_out
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_PREP   = 3'd1;
    localparam logic [2:0] S_WRITE  = 3'd2;
    localparam logic [2:0] S_DIV    = 3'd3;
    localparam logic [2:0] S_ADDR   = 3'd4;
    localparam logic [2:0] S_READ   = 3'd5;
    localparam logic [2:0] S_RESULT = 3'd6;

    logic [nns_pkg::DIM_W-1:0] r_src_width;
    logic [nns_pkg::DIM_W-1:0] r_src_height;
    logic [nns_pkg::DIM_W-1:0] r_dst_width;
    logic [nns_pkg::DIM_W-1:0] r_dst_height;
    logic [nns_pkg::DIM_W-1:0] sw;
    logic [nns_pkg::DIM_W-1:0] sh;
    logic [nns_pkg::DIM_W-1:0] dw;
    logic [nns_pkg::DIM_W-1:0] dh;

    logic [2:0]                r_state;
    logic [2:0]                n_state;
    nns_pkg::t_in_item         r_item;
    logic [nns_pkg::ST_AW-1:0] r_addr;
    logic                      r_bad;
    logic                      r_out_valid;
    nns_pkg::t_out_item        r_out;

    logic                       in_accept;
    logic                       dst_bad;
    logic                       src_bad;
    logic                       div_start;
    logic [nns_pkg::NUM_W-1:0]  num_x;
    logic [nns_pkg::NUM_W-1:0]  num_y;
    logic [nns_pkg::NUM_W-1:0]  quo_x;
    logic [nns_pkg::NUM_W-1:0]  quo_y;
    logic                       done_x;
    logic                       done_y;
    logic [nns_pkg::DIM_W-1:0]  row;
    logic [nns_pkg::DIM_W-1:0]  col;
    logic [nns_pkg::ADDR_W-1:0] addr;
    logic                       in_bounds;
    logic                       addr_ok;
    logic                       out_free;
    logic [nns_pkg::OUT_W-1:0]  pix;
    logic [nns_pkg::PIX_W-1:0]  rd_data;
    nns_pkg::t_store_req        store_req;

    assign sw = nns_pkg::clamp_dim(r_src_width);
    assign sh = nns_pkg::clamp_dim(r_src_height);
    assign dw = nns_pkg::clamp_dim(r_dst_width);
    assign dh = nns_pkg::clamp_dim(r_dst_height);

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width  <= nns_pkg::DIM_W'(1);
            r_src_height <= nns_pkg::DIM_W'(1);
            r_dst_width  <= nns_pkg::DIM_W'(1);
            r_dst_height <= nns_pkg::DIM_W'(1);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                nns_pkg::REG_SRC_WIDTH:  r_src_width  <= i_cfg_data;
                nns_pkg::REG_SRC_HEIGHT: r_src_height <= i_cfg_data;
                nns_pkg::REG_DST_WIDTH:  r_dst_width  <= i_cfg_data;
                nns_pkg::REG_DST_HEIGHT: r_dst_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_in_ready = (r_state == S_IDLE);
    assign in_accept  = i_in_valid && o_in_ready;
    assign out_free   = !r_out_valid || i_out_ready;

    assign dst_bad = ({1'b0, r_item.pos_x} >= dw) || ({1'b0, r_item.pos_y} >= dh);
    assign src_bad = ({1'b0, r_item.pos_x} >= sw) || ({1'b0, r_item.pos_y} >= sh);

    assign num_x     = nns_pkg::NUM_W'(r_item.pos_x) * nns_pkg::NUM_W'(sw);
    assign num_y     = nns_pkg::NUM_W'(r_item.pos_y) * nns_pkg::NUM_W'(sh);
    assign div_start = (r_state == S_PREP) && (r_item.operation == nns_pkg::OP_FETCH)
                       && !dst_bad;

    nns_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_x),
        .i_den   (dw),
        .o_done  (done_x),
        .o_quo   (quo_x)
    );

    nns_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (num_y),
        .i_den   (dh),
        .o_done  (done_y),
        .o_quo   (quo_y)
    );

    // The address multiplier serves the load position and the mapped fetch position.
    always_comb begin
        if (r_state == S_PREP) begin
            row       = nns_pkg::DIM_W'(r_item.pos_y);
            col       = nns_pkg::DIM_W'(r_item.pos_x);
            in_bounds = !src_bad;
        end else begin
            row       = quo_y[nns_pkg::DIM_W-1:0];
            col       = quo_x[nns_pkg::DIM_W-1:0];
            in_bounds = (quo_x < nns_pkg::NUM_W'(sw)) && (quo_y < nns_pkg::NUM_W'(sh));
        end
        addr    = nns_pkg::ADDR_W'(row) * nns_pkg::ADDR_W'(sw) + nns_pkg::ADDR_W'(col);
        addr_ok = in_bounds && (addr < nns_pkg::ADDR_W'(nns_pkg::STORE_DEPTH));
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_accept) begin
                    n_state = S_PREP;
                end
            end
            S_PREP: begin
                if (r_item.operation == nns_pkg::OP_LOAD) begin
                    n_state = S_WRITE;
                end else if (dst_bad) begin
                    n_state = S_RESULT;
                end else begin
                    n_state = S_DIV;
                end
            end
            S_WRITE: n_state = S_IDLE;
            S_DIV: begin
                if (done_x) begin
                    n_state = S_ADDR;
                end
            end
            S_ADDR:  n_state = S_READ;
            S_READ:  n_state = S_RESULT;
            S_RESULT: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if ((r_state == S_RESULT) && out_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item <= i_in;
        end
        if (r_state == S_PREP) begin
            r_addr <= addr[nns_pkg::ST_AW-1:0];
            r_bad  <= (r_item.operation == nns_pkg::OP_LOAD) ? !addr_ok : dst_bad;
        end else if (r_state == S_ADDR) begin
            r_addr <= addr[nns_pkg::ST_AW-1:0];
            r_bad  <= !addr_ok;
        end
        if ((r_state == S_RESULT) && out_free) begin
            r_out.pixel_565     <= pix;
            r_out.pixel_swapped <= {pix[7:0], pix[15:8]};
            r_out.out_of_range  <= r_bad;
        end
    end

    assign store_req.we    = (r_state == S_WRITE) && !r_bad;
    assign store_req.re    = (r_state == S_READ) && !r_bad;
    assign store_req.addr  = r_addr;
    assign store_req.wdata = {r_item.red, r_item.green, r_item.blue};

    nns_store u_store (
        .i_clk     (i_clk),
        .i_req     (store_req),
        .o_rd_data (rd_data)
    );

    assign pix = r_bad ? '0 : nns_pkg::pack565(rd_data);

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    a_div_lockstep : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done_x |-> done_y)
        else $error("column and row dividers finished apart");

    a_no_rw_clash : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(store_req.we && store_req.re))
        else $error("frame store read and written in one cycle");

    a_bad_is_zero : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out.out_of_range) |-> (o_out.pixel_565 == '0))
        else $error("rejected fetch carries a non-zero pixel");

    a_swap_match : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.pixel_swapped == {o_out.pixel_565[7:0], o_out.pixel_565[15:8]}))
        else $error("swapped pixel does not match plain pixel");

endmodule

[rtl/nns_div.sv]
module nns_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [nns_pkg::NUM_W-1:0] i_num,
    input  logic [nns_pkg::DIM_W-1:0] i_den,
    output logic                      o_done,
    output logic [nns_pkg::NUM_W-1:0] o_quo
);

    logic [nns_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                          r_done;
    logic [nns_pkg::NUM_W-1:0]     r_quo;
    logic [nns_pkg::DIM_W-1:0]     r_rem;
    logic [nns_pkg::DIM_W-1:0]     n_rem;
    logic [nns_pkg::DIM_W:0]       trial;
    logic                          q_bit;

    // One quotient bit per cycle; the remainder always stays below the divisor.
    always_comb begin
        trial = {r_rem, r_quo[nns_pkg::NUM_W-1]};
        q_bit = (trial >= {1'b0, i_den});
        n_rem = q_bit ? nns_pkg::DIM_W'(trial - {1'b0, i_den})
                      : trial[nns_pkg::DIM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt <= nns_pkg::DIV_CNT_W'(nns_pkg::NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == nns_pkg::DIV_CNT_W'(1)) begin
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_rem <= '0;
        end else if (r_cnt != '0) begin
            r_quo <= {r_quo[nns_pkg::NUM_W-2:0], q_bit};
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

[rtl/nns_store.sv]
module nns_store (
    input  logic                      i_clk,
    input  nns_pkg::t_store_req       i_req,
    output logic [nns_pkg::PIX_W-1:0] o_rd_data
);

    logic [nns_pkg::PIX_W-1:0] mem [nns_pkg::STORE_DEPTH];
    logic [nns_pkg::PIX_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            mem[i_req.addr] <= i_req.wdata;
        end
        if (i_req.re) begin
            r_rd_data <= mem[i_req.addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

[tb/sv/nearest_neighbor_scaler_rgb565_unit_test.sv]
module nearest_neighbor_scaler_rgb565_unit_test;

    import nns_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SRC_WIDTH;
    logic [DIM_W-1:0]     cfg_data = '0;
    logic                 in_valid = 1'b0;
    logic                 o_in_ready;
    t_in_item             in_item = '0;
    logic                 o_out_valid;
    logic                 out_ready = 1'b0;
    t_out_item            o_out;

    t_in_item             beats_to_send [$];
    t_out_item            pixels_due [$];
    logic [PIX_W-1:0]     frame_copy [STORE_DEPTH];
    bit                   loaded [STORE_DEPTH];
    logic [DIM_W-1:0]     dims [4] = '{default: DIM_W'(1)};
    bit                   idle_mode = 1'b1;
    int unsigned          useful = 0;
    int unsigned          mismatches = 0;
    int unsigned          send_gap = 0;
    int unsigned          stall_left = 0;
    t_out_item            want_pixel;

    nearest_neighbor_scaler_rgb565_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (out_ready),
        .o_out       (o_out)
    );

    always #5 i_clk = ~i_clk;

    function automatic int unsigned dim(input logic [CFG_IDX_W-1:0] r);
        return (dims[r] > MAX_DIM) ? MAX_DIM : dims[r];
    endfunction

    function automatic bit load_address(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                        output int unsigned a);
        a = y * dim(REG_SRC_WIDTH) + x;
        return x < dim(REG_SRC_WIDTH) && y < dim(REG_SRC_HEIGHT) && a < STORE_DEPTH;
    endfunction

    // True when a fetch at this destination coordinate reads the store at address a.
    function automatic bit src_address(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                       output int unsigned a);
        int unsigned sx;
        int unsigned sy;
        a = 0;
        if (x >= dim(REG_DST_WIDTH) || y >= dim(REG_DST_HEIGHT)) begin
            return 1'b0;
        end
        sx = x * dim(REG_SRC_WIDTH) / dim(REG_DST_WIDTH);
        sy = y * dim(REG_SRC_HEIGHT) / dim(REG_DST_HEIGHT);
        a = sy * dim(REG_SRC_WIDTH) + sx;
        return sx < dim(REG_SRC_WIDTH) && sy < dim(REG_SRC_HEIGHT) && a < STORE_DEPTH;
    endfunction

    function automatic void track_beat(input t_in_item it);
        t_out_item        r;
        int unsigned      a;
        logic [OUT_W-1:0] p;
        r = '0;
        if (it.operation == OP_LOAD) begin
            if (load_address(it.pos_x, it.pos_y, a)) begin
                frame_copy[a] = {it.red, it.green, it.blue};
            end
        end else begin
            if (src_address(it.pos_x, it.pos_y, a)) begin
                p = {frame_copy[a][23:19], frame_copy[a][15:10], frame_copy[a][7:3]};
                r.pixel_565 = p;
                r.pixel_swapped = {p[7:0], p[15:8]};
            end else begin
                r.out_of_range = 1'b1;
            end
            pixels_due.push_back(r);
        end
    endfunction

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(99);
        if (!idle_mode || roll < 55) begin
            return 0;
        end
        if (roll < 92) begin
            return $urandom_range(3, 1);
        end
        return $urandom_range(40, 8);
    endfunction

    function automatic logic [DIM_W-1:0] pick_dim(input bit source);
        int unsigned roll;
        roll = $urandom_range(9);
        if (roll == 0) begin
            case ($urandom_range(3))
                0: return DIM_W'(0);
                1: return DIM_W'(1);
                2: return DIM_W'(MAX_DIM);
                default: return {DIM_W{1'b1}};
            endcase
        end
        if (roll == 1) begin
            return DIM_W'($urandom_range(2047, 1));
        end
        return DIM_W'(source ? $urandom_range(40, 1) : $urandom_range(120, 1));
    endfunction

    task automatic queue_load(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                              input logic [PIX_W-1:0] rgb);
        t_in_item    it;
        int unsigned a;
        it.operation = OP_LOAD;
        it.pos_x = x;
        it.pos_y = y;
        {it.red, it.green, it.blue} = rgb;
        if (load_address(x, y, a)) begin
            loaded[a] = 1'b1;
        end
        useful++;
        beats_to_send.push_back(it);
    endtask

    // A fetch that would land on a pixel never loaded gets that pixel loaded first.
    task automatic queue_fetch(input logic [POS_W-1:0] x, input logic [POS_W-1:0] y);
        t_in_item    it;
        int unsigned a;
        if (src_address(x, y, a) && !loaded[a]) begin
            queue_load(POS_W'(a % dim(REG_SRC_WIDTH)), POS_W'(a / dim(REG_SRC_WIDTH)),
                       PIX_W'($urandom));
        end
        it.operation = OP_FETCH;
        it.pos_x = x;
        it.pos_y = y;
        {it.red, it.green, it.blue} = PIX_W'($urandom);
        useful++;
        beats_to_send.push_back(it);
    endtask

    task automatic settle();
        do @(negedge i_clk);
        while (beats_to_send.size() != 0 || in_valid || pixels_due.size() != 0);
        repeat (30) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_valid <= 1'b0;
        dims[idx] = val;
    endtask

    task automatic write_dims(input logic [DIM_W-1:0] sw, input logic [DIM_W-1:0] sh,
                              input logic [DIM_W-1:0] dw, input logic [DIM_W-1:0] dh);
        write_reg(REG_SRC_WIDTH, sw);
        write_reg(REG_SRC_HEIGHT, sh);
        write_reg(REG_DST_WIDTH, dw);
        write_reg(REG_DST_HEIGHT, dh);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && o_in_ready) begin
                track_beat(in_item);
            end
            if (!in_valid || o_in_ready) begin
                if (send_gap > 0) begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end else if (beats_to_send.size() != 0) begin
                    in_item <= beats_to_send.pop_front();
                    in_valid <= 1'b1;
                    send_gap <= pick_gap();
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && out_ready) begin
                if (pixels_due.size() == 0) begin
                    $error("result beat with nothing expected: pixel_565 %h", o_out.pixel_565);
                    mismatches++;
                end else begin
                    want_pixel = pixels_due.pop_front();
                    if (o_out.pixel_565 !== want_pixel.pixel_565) begin
                        $error("pixel_565: expected %h, got %h",
                               want_pixel.pixel_565, o_out.pixel_565);
                        mismatches++;
                    end
                    if (o_out.pixel_swapped !== want_pixel.pixel_swapped) begin
                        $error("pixel_swapped: expected %h, got %h",
                               want_pixel.pixel_swapped, o_out.pixel_swapped);
                        mismatches++;
                    end
                    if (o_out.out_of_range !== want_pixel.out_of_range) begin
                        $error("out_of_range: expected %b, got %b",
                               want_pixel.out_of_range, o_out.out_of_range);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                out_ready <= 1'b0;
                stall_left <= stall_left - 1;
            end else begin
                out_ready <= 1'b1;
                if ($urandom_range(3) == 0) begin
                    stall_left <= pick_gap();
                end
            end
        end
    end

    initial begin
        #10000000;
        $display("nearest_neighbor_scaler_rgb565_unit_test: errors");
        $finish;
    end

    initial begin
        int unsigned target;
        int unsigned roll;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        queue_load(0, 0, 24'hFFFFFF);
        queue_fetch(0, 0);
        queue_fetch(1, 0);
        queue_fetch(0, 1);
        queue_load(1, 0, 24'h123456);
        queue_load(0, 0, 24'h000000);
        queue_fetch(0, 0);
        queue_fetch(1023, 1023);
        settle();

        write_dims(DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
        queue_load(1023, 127, 24'hF80407);
        queue_load(0, 128, 24'hFFFFFF);
        queue_fetch(1023, 127);
        queue_fetch(0, 128);
        queue_load(0, 0, 24'h07FBF8);
        queue_fetch(0, 0);
        queue_fetch(512, 0);
        queue_load(1023, 1023, 24'hFFFFFF);
        settle();

        write_dims(DIM_W'(0), DIM_W'(5), {DIM_W{1'b1}}, DIM_W'(3));
        queue_load(0, 0, 24'hFFFFFF);
        queue_fetch(1023, 2);
        queue_fetch(0, 3);
        settle();

        write_dims(DIM_W'(3), DIM_W'(2), DIM_W'(MAX_DIM), DIM_W'(MAX_DIM));
        queue_fetch(1023, 1023);
        queue_fetch(0, 0);

        useful = 0;
        while (useful < 1450) begin
            settle();
            idle_mode = ($urandom_range(3) != 0);
            write_dims(pick_dim(1'b1), pick_dim(1'b1), pick_dim(1'b0), pick_dim(1'b0));
            target = useful + $urandom_range(160, 80);
            if (target > 1450) begin
                target = 1450;
            end
            while (useful < target) begin
                roll = $urandom_range(99);
                if (roll < 60) begin
                    if (dim(REG_DST_WIDTH) != 0 && dim(REG_DST_HEIGHT) != 0) begin
                        queue_fetch(POS_W'($urandom_range(dim(REG_DST_WIDTH) - 1)),
                                    POS_W'($urandom_range(dim(REG_DST_HEIGHT) - 1)));
                    end else begin
                        queue_fetch(POS_W'($urandom), POS_W'($urandom));
                    end
                end else if (roll < 80 && dim(REG_SRC_WIDTH) != 0
                             && dim(REG_SRC_HEIGHT) != 0) begin
                    queue_load(POS_W'($urandom_range(dim(REG_SRC_WIDTH) - 1)),
                               POS_W'($urandom_range(dim(REG_SRC_HEIGHT) - 1)),
                               PIX_W'($urandom));
                end else if (roll < 90) begin
                    queue_fetch(POS_W'($urandom), POS_W'($urandom));
                end else begin
                    queue_load(POS_W'($urandom), POS_W'($urandom), PIX_W'($urandom));
                end
            end
        end
        settle();

        if (mismatches == 0) begin
            $display("nearest_neighbor_scaler_rgb565_unit_test: clean");
        end else begin
            $display("nearest_neighbor_scaler_rgb565_unit_test: errors");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/nns_pkg.sv
rtl/nns_div.sv
rtl/nns_store.sv
rtl/nearest_neighbor_scaler_rgb565_unit.sv
tb/sv/nearest_neighbor_scaler_rgb565_unit_test.sv
